[rtl/asre_pkg.sv]
// shared types and codes for the array search and remove engine
`default_nettype none

package asre_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEQ    = 2'd1,
    OP_BIN    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic load;
    logic append;
    logic set_full;
    logic set_range;
    logic walk;
    logic bin_rd;
    logic bin_cmp;
    logic dec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic idx_bad;
    logic walk_done;
    logic bin_open;
    logic bin_eq;
  } sts_t;

endpackage

`default_nettype wire

[rtl/asre_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module asre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/asre_ctrl.sv]
// controller state machine sequencing each operation
`default_nettype none

module asre_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire asre_pkg::sts_t sts,
  output asre_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_WALK,
    S_BIN_RD,
    S_BIN_CMP,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          asre_pkg::OP_APPEND: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.append = 1'b1;
            end
            state_next = S_FIN;
          end
          asre_pkg::OP_SEQ: state_next = S_WALK;
          asre_pkg::OP_BIN: state_next = S_BIN_RD;
          asre_pkg::OP_REMOVE: begin
            if (sts.idx_bad) begin
              cmd.set_range = 1'b1;
              state_next    = S_FIN;
            end else begin
              state_next = S_WALK;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          cmd.dec    = (sts.op == asre_pkg::OP_REMOVE);
          state_next = S_FIN;
        end
      end
      S_BIN_RD: begin
        if (sts.bin_open) begin
          cmd.bin_rd = 1'b1;
          state_next = S_BIN_CMP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_BIN_CMP: begin
        cmd.bin_cmp = 1'b1;
        state_next  = sts.bin_eq ? S_FIN : S_BIN_RD;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/asre_dp.sv]
// datapath: list memory, count, walk pointers, search bounds and result registers
`default_nettype none

module asre_dp #(
  parameter int LIST_DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire asre_pkg::cmd_t     cmd,
  output asre_pkg::sts_t          sts,
  input  wire logic [1:0]         op,
  input  wire logic signed [15:0] search_key,
  input  wire logic [6:0]         remove_index,
  output logic                    found,
  output logic [6:0]              position,
  output logic [7:0]              entry_count,
  output logic [1:0]              status
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  asre_pkg::op_t      op_r;
  logic signed [15:0] key_r;
  logic [6:0]         idx_r;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_ptr;
  logic               pend;
  logic [AW-1:0]      pend_addr;
  logic               hit;
  logic [AW-1:0]      pos;
  logic [1:0]         st;
  logic signed [CW:0] lo;
  logic signed [CW:0] hi;
  logic [AW-1:0]      mid_r;

  logic signed [CW+1:0] sum;
  logic [AW-1:0]        mid;
  logic                 issue;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [15:0]          rdata;
  logic                 key_gt;

  assign sum    = (CW+2)'(lo) + (CW+2)'(hi);
  assign mid    = sum[AW:1];
  assign issue  = cmd.walk && (rd_ptr < count);
  assign raddr  = cmd.bin_rd ? mid : rd_ptr[AW-1:0];
  assign key_gt = key_r > $signed(rdata);

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    if (cmd.append) begin
      we = 1'b1;
    end else if (cmd.walk && pend && op_r == asre_pkg::OP_REMOVE) begin
      we    = 1'b1;
      waddr = pend_addr - AW'(1);
    end
  end

  asre_ram #(
    .WIDTH(16),
    .DEPTH(LIST_DEPTH)
  ) u_list (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cmd.append ? key_r : rdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sts.op        = op_r;
  assign sts.full      = (count == CW'(LIST_DEPTH));
  assign sts.idx_bad   = (XW'(idx_r) >= XW'(count));
  assign sts.walk_done = (rd_ptr >= count) && !pend;
  assign sts.bin_open  = (lo <= hi);
  assign sts.bin_eq    = (rdata == key_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CW'(1);
    end else if (cmd.dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= asre_pkg::op_t'(op);
      key_r <= search_key;
      idx_r <= remove_index;
      hit   <= 1'b0;
      pos   <= '0;
      st    <= asre_pkg::ST_OK;
      pend  <= 1'b0;
      lo    <= '0;
      hi    <= $signed({1'b0, count}) - (CW+1)'(1);
      if (asre_pkg::op_t'(op) == asre_pkg::OP_REMOVE) begin
        rd_ptr <= CW'(remove_index) + CW'(1);
      end else begin
        rd_ptr <= '0;
      end
    end else begin
      if (cmd.set_full) begin
        st <= asre_pkg::ST_FULL;
      end
      if (cmd.set_range) begin
        st <= asre_pkg::ST_RANGE;
      end
      if (cmd.walk) begin
        pend      <= issue;
        pend_addr <= rd_ptr[AW-1:0];
        if (issue) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
        if (pend && op_r == asre_pkg::OP_SEQ && rdata == key_r) begin
          hit <= 1'b1;
          pos <= pend_addr;
        end
      end
      if (cmd.bin_rd) begin
        mid_r <= mid;
      end
      if (cmd.bin_cmp) begin
        if (rdata == key_r) begin
          hit <= 1'b1;
          pos <= mid_r;
        end else if (key_gt) begin
          lo <= $signed((CW+1)'(mid_r)) + (CW+1)'(1);
        end else begin
          hi <= $signed((CW+1)'(mid_r)) - (CW+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= hit;
      position    <= hit ? 7'(pos) : 7'd0;
      entry_count <= 8'(count);
      status      <= st;
    end
  end

endmodule

`default_nettype wire

[rtl/array_search_remove_engine_core.sv]
// top level of the array search and remove engine
`default_nettype none

// Holds up to LIST_DEPTH signed 16-bit entries in one memory with a registered
// read port and takes one operation per input beat: append, sequential search
// (last match), binary search (first matching midpoint) or remove at index.
// Exactly one result beat follows each input beat. Sequential search and remove
// walk the list through the memory read port one entry per cycle: search over
// every entry, remove over the entries above remove_index, each moved down one
// place. Binary search reads and then compares one midpoint per probe. One
// operation is worked on at a time; the result sits in an output register so
// the next input beat is taken while the previous result still waits.
module array_search_remove_engine_core #(
  parameter int LIST_DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic signed [15:0] search_key,
  input  wire logic [6:0]         remove_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    found,
  output logic [6:0]              position,
  output logic [7:0]              entry_count,
  output logic [1:0]              status
);

  asre_pkg::cmd_t cmd;
  asre_pkg::sts_t sts;

  asre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  asre_dp #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .search_key  (search_key),
    .remove_index(remove_index),
    .found       (found),
    .position    (position),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule

`default_nettype wire
